[rtl/asgr_pkg.sv]
// Package for the ANSI SGR text attribute decoder.
// Holds byte codes, result kinds, parser phase type and the SGR color palette.
// No dependencies.
`timescale 1ns / 1ps

package asgr_pkg;

    // Result kinds
    localparam logic [1:0] KIND_GLYPH   = 2'd0;
    localparam logic [1:0] KIND_NEWLINE = 2'd1;
    localparam logic [1:0] KIND_CR      = 2'd2;
    localparam logic [1:0] KIND_ABSORB  = 2'd3;

    // Stream bytes with special meaning
    localparam logic [7:0] BYTE_BELL   = 8'h07;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_FF     = 8'h0C;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;
    localparam logic [7:0] BYTE_SEMI   = 8'h3B;
    localparam logic [7:0] BYTE_M      = 8'h6D;
    localparam logic [7:0] BYTE_ZERO   = 8'h30;
    localparam logic [7:0] BYTE_NINE   = 8'h39;

    // SGR codes handled
    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_BOLD       = 8'd1;
    localparam logic [7:0] SGR_ITALIC     = 8'd3;
    localparam logic [7:0] SGR_UNDERLINE  = 8'd4;
    localparam logic [7:0] SGR_REVERSE    = 8'd7;
    localparam logic [7:0] SGR_BOLD_OFF   = 8'd21;
    localparam logic [7:0] SGR_ITALIC_OFF = 8'd23;
    localparam logic [7:0] SGR_UNDER_OFF  = 8'd24;
    localparam logic [7:0] SGR_REV_OFF    = 8'd27;
    localparam logic [7:0] SGR_FG_FIRST   = 8'd30;
    localparam logic [7:0] SGR_FG_LAST    = 8'd37;
    localparam logic [7:0] SGR_BG_FIRST   = 8'd40;
    localparam logic [7:0] SGR_BG_LAST    = 8'd46;
    localparam logic [7:0] SGR_BG_WHITE   = 8'd47;

    // Parameter accumulator saturation value
    localparam logic [7:0] ACC_MAX = 8'd255;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_FG = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_BG = 4'd1;

    // Reset colors
    localparam logic [23:0] FG_RESET_RGB = 24'hA1A1A1;
    localparam logic [23:0] BG_RESET_RGB = 24'h000000;
    localparam logic [23:0] WHITE_RGB    = 24'hFFFFFF;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_CSI  = 3'b100
    } phase_t;

    // Eight-entry basic palette
    function automatic logic [23:0] palette_rgb(input logic [2:0] idx);
        logic [23:0] rgb;
        case (idx)
            3'd0:    rgb = 24'h000000;
            3'd1:    rgb = 24'h800000;
            3'd2:    rgb = 24'h008000;
            3'd3:    rgb = 24'h808000;
            3'd4:    rgb = 24'h000080;
            3'd5:    rgb = 24'h800080;
            3'd6:    rgb = 24'h008080;
            default: rgb = 24'hC0C0C0;
        endcase
        return rgb;
    endfunction

endpackage

[rtl/ansi_sgr_text_attribute_decoder_core.sv]
// Top level of the ANSI SGR text attribute decoder.
// Depends on asgr_pkg for byte codes, kinds, phase type and palette.
`timescale 1ns / 1ps

// Decodes a text byte stream into one result item per input byte: kind,
// glyph, cursor cell, attributes and effective colors. The block takes one
// item every cycle while results are taken; each item goes from the input
// register through a single-pass decode into the result register. A result
// that waits on m_ready stalls the input once the input register holds an
// item. The user must write default colors through the cfg port only while
// the block is idle; the block itself does not enforce this.
module ansi_sgr_text_attribute_decoder_core #(
    parameter int unsigned CURSOR_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_byte_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_kind,
    output logic [7:0]                        m_glyph,
    output logic [15:0]                       m_column,
    output logic [15:0]                       m_row,
    output logic                              m_bold_on,
    output logic                              m_italic_on,
    output logic                              m_underline_on,
    output logic [23:0]                       m_paint_fg_rgb,
    output logic [23:0]                       m_paint_bg_rgb,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [asgr_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [23:0]                       cfg_data
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Configuration registers
    logic [23:0] default_fg_reg;
    logic [23:0] default_bg_reg;

    // Decoder state
    asgr_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]             acc_reg, acc_next;
    logic                   bold_reg, bold_next;
    logic                   italic_reg, italic_next;
    logic                   under_reg, under_next;
    logic                   rev_reg, rev_next;
    logic [23:0]            fg_reg, fg_next;
    logic [23:0]            bg_reg, bg_next;
    logic [CURSOR_BITS-1:0] col_reg, col_next;
    logic [CURSOR_BITS-1:0] row_reg, row_next;

    // Result register
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [7:0]  m_glyph_reg, m_glyph_next;
    logic [15:0] m_column_reg, m_column_next;
    logic [15:0] m_row_reg, m_row_next;
    logic        m_bold_reg, m_italic_reg, m_under_reg;
    logic [23:0] m_fg_reg, m_fg_next;
    logic [23:0] m_bg_reg, m_bg_next;

    // Decode helpers
    logic                    advance;
    logic                    plain_en;
    logic                    apply_en;
    logic                    style_rst;
    logic [7:0]              digit_diff;
    logic [11:0]             acc_prod;
    logic [CURSOR_BITS-1:0]  col_out;
    logic [CURSOR_BITS+15:0] col_wide;
    logic [CURSOR_BITS+15:0] row_wide;
    logic [7:0]              fg_off;
    logic [7:0]              bg_off;

    // Stage moves when an item is held and the result register frees up
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign digit_diff = in_byte_reg - asgr_pkg::BYTE_ZERO;
    assign acc_prod   = ({4'd0, acc_reg} * 12'd10) + {8'd0, digit_diff[3:0]};
    assign fg_off     = acc_reg - asgr_pkg::SGR_FG_FIRST;
    assign bg_off     = acc_reg - asgr_pkg::SGR_BG_FIRST;

    // Parse the held byte and compute next state
    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        bold_next    = bold_reg;
        italic_next  = italic_reg;
        under_next   = under_reg;
        rev_next     = rev_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        m_kind_next  = asgr_pkg::KIND_ABSORB;
        plain_en     = 1'b0;
        apply_en     = 1'b0;
        style_rst    = 1'b0;

        case (phase_reg)
            asgr_pkg::PH_CSI: begin
                if (in_byte_reg inside {[asgr_pkg::BYTE_ZERO:asgr_pkg::BYTE_NINE]}) begin
                    acc_next = (acc_prod > {4'd0, asgr_pkg::ACC_MAX}) ?
                               asgr_pkg::ACC_MAX : acc_prod[7:0];
                end else if (in_byte_reg == asgr_pkg::BYTE_SEMI) begin
                    apply_en = 1'b1;
                    acc_next = 8'd0;
                end else begin
                    apply_en   = (in_byte_reg == asgr_pkg::BYTE_M);
                    acc_next   = 8'd0;
                    phase_next = asgr_pkg::PH_TEXT;
                end
            end
            asgr_pkg::PH_ESC: begin
                if (in_byte_reg == asgr_pkg::BYTE_LBRACK) begin
                    phase_next = asgr_pkg::PH_CSI;
                    acc_next   = 8'd0;
                end else begin
                    phase_next = asgr_pkg::PH_TEXT;
                    plain_en   = 1'b1;
                end
            end
            default: begin
                phase_next = asgr_pkg::PH_TEXT;
                plain_en   = 1'b1;
            end
        endcase

        // Plain-text byte
        if (plain_en) begin
            case (in_byte_reg)
                asgr_pkg::BYTE_BELL: m_kind_next = asgr_pkg::KIND_ABSORB;
                asgr_pkg::BYTE_FF: begin
                    style_rst   = 1'b1;
                    m_kind_next = asgr_pkg::KIND_ABSORB;
                end
                asgr_pkg::BYTE_ESC: begin
                    phase_next  = asgr_pkg::PH_ESC;
                    m_kind_next = asgr_pkg::KIND_ABSORB;
                end
                asgr_pkg::BYTE_LF: begin
                    row_next    = row_reg + {{(CURSOR_BITS-1){1'b0}}, 1'b1};
                    col_next    = '0;
                    m_kind_next = asgr_pkg::KIND_NEWLINE;
                end
                asgr_pkg::BYTE_CR: begin
                    col_next    = '0;
                    m_kind_next = asgr_pkg::KIND_CR;
                end
                default: begin
                    col_next    = col_reg + {{(CURSOR_BITS-1){1'b0}}, 1'b1};
                    m_kind_next = asgr_pkg::KIND_GLYPH;
                end
            endcase
        end

        // Apply the SGR parameter
        if (apply_en) begin
            case (acc_reg)
                asgr_pkg::SGR_RESET:      style_rst   = 1'b1;
                asgr_pkg::SGR_BOLD:       bold_next   = 1'b1;
                asgr_pkg::SGR_ITALIC:     italic_next = 1'b1;
                asgr_pkg::SGR_UNDERLINE:  under_next  = 1'b1;
                asgr_pkg::SGR_REVERSE:    rev_next    = 1'b1;
                asgr_pkg::SGR_BOLD_OFF:   bold_next   = 1'b0;
                asgr_pkg::SGR_ITALIC_OFF: italic_next = 1'b0;
                asgr_pkg::SGR_UNDER_OFF:  under_next  = 1'b0;
                asgr_pkg::SGR_REV_OFF:    rev_next    = 1'b0;
                asgr_pkg::SGR_BG_WHITE:   bg_next     = asgr_pkg::WHITE_RGB;
                default: begin
                    if (acc_reg inside {[asgr_pkg::SGR_FG_FIRST:asgr_pkg::SGR_FG_LAST]}) begin
                        fg_next = asgr_pkg::palette_rgb(fg_off[2:0]);
                    end else if (acc_reg inside
                                 {[asgr_pkg::SGR_BG_FIRST:asgr_pkg::SGR_BG_LAST]}) begin
                        bg_next = asgr_pkg::palette_rgb(bg_off[2:0]);
                    end
                end
            endcase
        end

        // Restore the default style
        if (style_rst) begin
            bold_next   = 1'b0;
            italic_next = 1'b0;
            under_next  = 1'b0;
            rev_next    = 1'b0;
            fg_next     = default_fg_reg;
            bg_next     = default_bg_reg;
        end
    end

    // Build the result fields
    always_comb begin
        col_out        = (m_kind_next == asgr_pkg::KIND_GLYPH) ? col_reg : col_next;
        col_wide       = {16'd0, col_out};
        row_wide       = {16'd0, row_next};
        m_column_next  = col_wide[15:0];
        m_row_next     = row_wide[15:0];
        m_glyph_next   = (m_kind_next == asgr_pkg::KIND_GLYPH) ? in_byte_reg : 8'd0;
        m_fg_next      = rev_next ? bg_next : fg_next;
        m_bg_next      = rev_next ? fg_next : bg_next;
    end

    // Hold the input item until it can be decoded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_fg_reg <= asgr_pkg::FG_RESET_RGB;
            default_bg_reg <= asgr_pkg::BG_RESET_RGB;
        end else if (cfg_wr_en) begin
            if (cfg_index == asgr_pkg::CFG_DEFAULT_FG) begin
                default_fg_reg <= cfg_data;
            end else if (cfg_index == asgr_pkg::CFG_DEFAULT_BG) begin
                default_bg_reg <= cfg_data;
            end
        end
    end

    // Advance decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= asgr_pkg::PH_TEXT;
            acc_reg    <= 8'd0;
            bold_reg   <= 1'b0;
            italic_reg <= 1'b0;
            under_reg  <= 1'b0;
            rev_reg    <= 1'b0;
            fg_reg     <= asgr_pkg::FG_RESET_RGB;
            bg_reg     <= asgr_pkg::BG_RESET_RGB;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            bold_reg   <= bold_next;
            italic_reg <= italic_next;
            under_reg  <= under_next;
            rev_reg    <= rev_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Result valid: set on advance, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_kind_reg   <= m_kind_next;
            m_glyph_reg  <= m_glyph_next;
            m_column_reg <= m_column_next;
            m_row_reg    <= m_row_next;
            m_bold_reg   <= bold_next;
            m_italic_reg <= italic_next;
            m_under_reg  <= under_next;
            m_fg_reg     <= m_fg_next;
            m_bg_reg     <= m_bg_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_glyph        = m_glyph_reg;
    assign m_column       = m_column_reg;
    assign m_row          = m_row_reg;
    assign m_bold_on      = m_bold_reg;
    assign m_italic_on    = m_italic_reg;
    assign m_underline_on = m_under_reg;
    assign m_paint_fg_rgb = m_fg_reg;
    assign m_paint_bg_rgb = m_bg_reg;

    // Bytes inside a sequence never produce a glyph
    a_csi_absorbs: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (phase_reg == asgr_pkg::PH_CSI) |=> m_kind == asgr_pkg::KIND_ABSORB)
        else $error("byte inside SGR sequence not absorbed");

    // Newline and carriage return leave the cursor at column zero
    a_line_col_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == asgr_pkg::KIND_NEWLINE || m_kind == asgr_pkg::KIND_CR)
        |-> m_column == 16'd0)
        else $error("line control result with nonzero column");

    // Glyph field is zero for every non-glyph result
    a_glyph_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != asgr_pkg::KIND_GLYPH) |-> m_glyph == 8'd0)
        else $error("glyph set on non-glyph result");

    // Input stalls only while an item is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg)
        else $error("input stalled without a held item");

    // Leaving a sequence always clears the accumulator
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (phase_reg == asgr_pkg::PH_CSI) && (phase_next != asgr_pkg::PH_CSI)
        |=> acc_reg == 8'd0)
        else $error("parameter accumulator not cleared at sequence end");

endmodule

[tb/ansi_sgr_text_attribute_decoder_core_tb.sv]
// Self-checking testbench for the ANSI SGR text attribute decoder core.
// Drives byte items with random idling and checks each result item against a predictor.
// Depends on asgr_pkg and ansi_sgr_text_attribute_decoder_core.
`timescale 1ns / 1ps

module ansi_sgr_text_attribute_decoder_core_tb;

    localparam int unsigned CURSOR_BITS  = 16;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          REPORT_LIMIT = 100;

    // Basic palette, entry 0 in the low bits
    localparam logic [8*24-1:0] BASIC_COLORS = {
        24'hC0C0C0, 24'h008080, 24'h800080, 24'h000080,
        24'h808000, 24'h008000, 24'h800000, 24'h000000
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  glyph;
        logic [15:0] column;
        logic [15:0] row;
        logic        bold;
        logic        italic;
        logic        underline;
        logic [23:0] fg;
        logic [23:0] bg;
    } term_cell_t;

    // DUT connections
    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [7:0]                         s_byte_value = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [1:0]                         m_kind;
    logic [7:0]                         m_glyph;
    logic [15:0]                        m_column;
    logic [15:0]                        m_row;
    logic                               m_bold_on;
    logic                               m_italic_on;
    logic                               m_underline_on;
    logic [23:0]                        m_paint_fg_rgb;
    logic [23:0]                        m_paint_bg_rgb;
    logic                               cfg_wr_en = 1'b0;
    logic [asgr_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [23:0]                        cfg_data = '0;

    // Predictor state
    logic [23:0]              default_fg = asgr_pkg::FG_RESET_RGB;
    logic [23:0]              default_bg = asgr_pkg::BG_RESET_RGB;
    asgr_pkg::phase_t         parse_phase = asgr_pkg::PH_TEXT;
    logic [7:0]               param_acc = '0;
    logic                     bold_flag = 1'b0;
    logic                     italic_flag = 1'b0;
    logic                     underline_flag = 1'b0;
    logic                     reverse_flag = 1'b0;
    logic [23:0]              current_fg = asgr_pkg::FG_RESET_RGB;
    logic [23:0]              current_bg = asgr_pkg::BG_RESET_RGB;
    logic [CURSOR_BITS-1:0]   cursor_col = '0;
    logic [CURSOR_BITS-1:0]   cursor_row = '0;

    term_cell_t               expected_cells [$];
    int                       error_count = 0;
    int                       items_sent = 0;
    int                       idle_cycles = 0;
    int                       src_idle_pct = 0;
    int                       sink_stall_pct = 0;

    logic [7:0] attr_codes [0:8] = '{
        asgr_pkg::SGR_RESET, asgr_pkg::SGR_BOLD, asgr_pkg::SGR_ITALIC,
        asgr_pkg::SGR_UNDERLINE, asgr_pkg::SGR_REVERSE, asgr_pkg::SGR_BOLD_OFF,
        asgr_pkg::SGR_ITALIC_OFF, asgr_pkg::SGR_UNDER_OFF, asgr_pkg::SGR_REV_OFF
    };
    logic [7:0] ctrl_bytes [0:3] = '{
        asgr_pkg::BYTE_LF, asgr_pkg::BYTE_CR, asgr_pkg::BYTE_FF, asgr_pkg::BYTE_BELL
    };

    ansi_sgr_text_attribute_decoder_core #(
        .CURSOR_BITS(CURSOR_BITS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_glyph        (m_glyph),
        .m_column       (m_column),
        .m_row          (m_row),
        .m_bold_on      (m_bold_on),
        .m_italic_on    (m_italic_on),
        .m_underline_on (m_underline_on),
        .m_paint_fg_rgb (m_paint_fg_rgb),
        .m_paint_bg_rgb (m_paint_bg_rgb),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    task automatic restore_style();
        bold_flag      = 1'b0;
        italic_flag    = 1'b0;
        underline_flag = 1'b0;
        reverse_flag   = 1'b0;
        current_fg     = default_fg;
        current_bg     = default_bg;
    endtask

    task automatic apply_sgr(input logic [7:0] code);
        logic [7:0] offset;
        case (code)
            asgr_pkg::SGR_RESET:      restore_style();
            asgr_pkg::SGR_BOLD:       bold_flag = 1'b1;
            asgr_pkg::SGR_ITALIC:     italic_flag = 1'b1;
            asgr_pkg::SGR_UNDERLINE:  underline_flag = 1'b1;
            asgr_pkg::SGR_REVERSE:    reverse_flag = 1'b1;
            asgr_pkg::SGR_BOLD_OFF:   bold_flag = 1'b0;
            asgr_pkg::SGR_ITALIC_OFF: italic_flag = 1'b0;
            asgr_pkg::SGR_UNDER_OFF:  underline_flag = 1'b0;
            asgr_pkg::SGR_REV_OFF:    reverse_flag = 1'b0;
            asgr_pkg::SGR_BG_WHITE:   current_bg = asgr_pkg::WHITE_RGB;
            default: begin
                // Palette colors; anything else leaves the style alone
                if (code >= asgr_pkg::SGR_FG_FIRST && code <= asgr_pkg::SGR_FG_LAST) begin
                    offset = code - asgr_pkg::SGR_FG_FIRST;
                    current_fg = BASIC_COLORS[offset[2:0]*24 +: 24];
                end else if (code >= asgr_pkg::SGR_BG_FIRST &&
                             code <= asgr_pkg::SGR_BG_LAST) begin
                    offset = code - asgr_pkg::SGR_BG_FIRST;
                    current_bg = BASIC_COLORS[offset[2:0]*24 +: 24];
                end
            end
        endcase
    endtask

    task automatic handle_text_byte(input logic [7:0] b, output logic [1:0] kind);
        case (b)
            asgr_pkg::BYTE_BELL: kind = asgr_pkg::KIND_ABSORB;
            asgr_pkg::BYTE_FF: begin
                restore_style();
                kind = asgr_pkg::KIND_ABSORB;
            end
            asgr_pkg::BYTE_ESC: begin
                parse_phase = asgr_pkg::PH_ESC;
                kind = asgr_pkg::KIND_ABSORB;
            end
            asgr_pkg::BYTE_LF: begin
                cursor_row = cursor_row + 1'b1;
                cursor_col = '0;
                kind = asgr_pkg::KIND_NEWLINE;
            end
            asgr_pkg::BYTE_CR: begin
                cursor_col = '0;
                kind = asgr_pkg::KIND_CR;
            end
            default: kind = asgr_pkg::KIND_GLYPH;
        endcase
    endtask

    // Advance the predictor by one accepted byte and queue its result
    task automatic decode_byte(input logic [7:0] b);
        term_cell_t want;
        logic [1:0] kind;
        int         acc_next;
        kind = asgr_pkg::KIND_ABSORB;
        case (parse_phase)
            asgr_pkg::PH_CSI: begin
                if (b >= asgr_pkg::BYTE_ZERO && b <= asgr_pkg::BYTE_NINE) begin
                    acc_next = int'(param_acc) * 10 + int'(b - asgr_pkg::BYTE_ZERO);
                    param_acc = (acc_next > int'(asgr_pkg::ACC_MAX)) ?
                                asgr_pkg::ACC_MAX : acc_next[7:0];
                end else if (b == asgr_pkg::BYTE_SEMI) begin
                    apply_sgr(param_acc);
                    param_acc = '0;
                end else begin
                    // 'm' applies the last parameter; any other byte just closes
                    if (b == asgr_pkg::BYTE_M)
                        apply_sgr(param_acc);
                    param_acc = '0;
                    parse_phase = asgr_pkg::PH_TEXT;
                end
            end
            asgr_pkg::PH_ESC: begin
                if (b == asgr_pkg::BYTE_LBRACK) begin
                    parse_phase = asgr_pkg::PH_CSI;
                    param_acc = '0;
                end else begin
                    parse_phase = asgr_pkg::PH_TEXT;
                    handle_text_byte(b, kind);
                end
            end
            default: handle_text_byte(b, kind);
        endcase

        want.kind      = kind;
        want.glyph     = (kind == asgr_pkg::KIND_GLYPH) ? b : 8'h00;
        want.column    = cursor_col;
        want.row       = cursor_row;
        if (kind == asgr_pkg::KIND_GLYPH)
            cursor_col = cursor_col + 1'b1;
        want.bold      = bold_flag;
        want.italic    = italic_flag;
        want.underline = underline_flag;
        want.fg        = reverse_flag ? current_bg : current_fg;
        want.bg        = reverse_flag ? current_fg : current_bg;
        expected_cells.push_back(want);
    endtask

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // Offer one byte, hold it until accepted, then predict its result
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_valid      <= 1'b1;
        s_byte_value <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
        decode_byte(b);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
    endtask

    // Drop valid and wait for every pending result
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge aclk);
    endtask

    // Write both default colors, then a write to an unused index that must be ignored
    task automatic configure(input logic [23:0] fg, input logic [23:0] bg);
        cfg_wr_en <= 1'b1;
        cfg_index <= asgr_pkg::CFG_DEFAULT_FG;
        cfg_data  <= fg;
        @(posedge aclk);
        default_fg = fg;
        cfg_index <= asgr_pkg::CFG_DEFAULT_BG;
        cfg_data  <= bg;
        @(posedge aclk);
        default_bg = bg;
        cfg_index <= asgr_pkg::CFG_IDX_BITS'($urandom_range(2,
                                                 (1 << asgr_pkg::CFG_IDX_BITS) - 1));
        cfg_data  <= 24'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("ERROR %s: got 0x%0h, expected 0x%0h (t=%0t)", what, got, want, $realtime);
    endtask

    // Randomize result backpressure and compare each accepted result item
    always @(posedge aclk) begin : result_checker
        term_cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                report_error("result with nothing pending, kind", 32'(m_kind), '0);
            end else begin
                want = expected_cells.pop_front();
                if (m_kind !== want.kind)
                    report_error("kind", 32'(m_kind), 32'(want.kind));
                if (m_glyph !== want.glyph)
                    report_error("glyph", 32'(m_glyph), 32'(want.glyph));
                if (m_column !== want.column)
                    report_error("column", 32'(m_column), 32'(want.column));
                if (m_row !== want.row)
                    report_error("row", 32'(m_row), 32'(want.row));
                if (m_bold_on !== want.bold)
                    report_error("bold", 32'(m_bold_on), 32'(want.bold));
                if (m_italic_on !== want.italic)
                    report_error("italic", 32'(m_italic_on), 32'(want.italic));
                if (m_underline_on !== want.underline)
                    report_error("underline", 32'(m_underline_on), 32'(want.underline));
                if (m_paint_fg_rgb !== want.fg)
                    report_error("paint fg", 32'(m_paint_fg_rgb), 32'(want.fg));
                if (m_paint_bg_rgb !== want.bg)
                    report_error("paint bg", 32'(m_paint_bg_rgb), 32'(want.bg));
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes straight out of reset; NUL and 0xFF draw as glyphs
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Bell, newline, carriage return and form feed
    task automatic test_control_bytes();
        send_text("\007\n\015\f");
    endtask

    // Attributes on, reverse swap, then bold off with white background
    task automatic test_sgr_attributes();
        send_text("\033[1;3;4;7m");
        send_text("\033[21;47mA");
    endtask

    // Empty parameter resets, large parameter saturates, foreign byte closes
    task automatic test_sgr_edge_cases();
        send_text("\033[;999x");
    endtask

    // Lone escape falls back to text; a second escape restarts the wait
    task automatic test_lone_escape();
        send_text("\033E\033\033[27m");
    endtask

    // Move column and row across several lines of glyphs
    task automatic test_cursor_walk();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (8) begin
            repeat ($urandom_range(1, 40))
                send_byte(8'($urandom_range(8'h20, 8'hFF)));
            send_byte(asgr_pkg::BYTE_LF);
        end
        send_byte(8'h7E);
    endtask

    // Mostly well-formed SGR sequences with random content, mixed with noise
    task automatic test_random_stream(input int n_items, input int src_pct, input int sink_pct);
        int    first;
        int    n_params;
        string param_text;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(99) < 55) begin
                send_byte(asgr_pkg::BYTE_ESC);
                send_byte(($urandom_range(9) != 0) ? asgr_pkg::BYTE_LBRACK :
                          8'($urandom_range(255)));
                n_params = $urandom_range(5);
                for (int p = 0; p < n_params; p++) begin
                    if (p != 0)
                        send_byte(asgr_pkg::BYTE_SEMI);
                    case ($urandom_range(9))
                        0, 1, 2, 3: param_text = $sformatf("%0d", attr_codes[$urandom_range(8)]);
                        4, 5:       param_text = $sformatf("%0d",
                                        asgr_pkg::SGR_FG_FIRST + $urandom_range(7));
                        6:          param_text = $sformatf("%0d",
                                        asgr_pkg::SGR_BG_FIRST + $urandom_range(7));
                        7:          param_text = $sformatf("%03d", $urandom_range(99));
                        8:          param_text = "";
                        default:    param_text = $sformatf("%0d", $urandom_range(256, 99999));
                    endcase
                    send_text(param_text);
                end
                send_byte(($urandom_range(99) < 85) ? asgr_pkg::BYTE_M :
                          8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: send_byte(8'($urandom_range(255)));
                        5, 6, 7:       send_byte(8'($urandom_range(8'h20, 8'h7E)));
                        8:             send_byte(ctrl_bytes[$urandom_range(3)]);
                        default:       send_byte(asgr_pkg::BYTE_ESC);
                    endcase
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(24'hFFFFFF, 24'h000000);
        test_reset_defaults();
        test_control_bytes();
        test_sgr_attributes();
        test_sgr_edge_cases();
        test_lone_escape();

        wait_idle();
        configure(24'h000000, 24'hFFFFFF);
        test_cursor_walk();

        wait_idle();
        configure(24'($urandom), 24'($urandom));
        test_random_stream(500, 0, 0);

        wait_idle();
        configure(24'($urandom), 24'($urandom));
        test_random_stream(500, 63, 0);

        wait_idle();
        configure(24'hFFFFFF, 24'hFFFFFF);
        test_random_stream(500, 0, 63);

        wait_idle();
        configure(24'h000000, 24'h000000);
        test_random_stream(500, 32, 32);

        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
